@@ rtl/gblur_pkg.sv @@
`default_nettype none
package gblur_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_BITS   = 8;
   localparam int RGB_BITS   = 3 * PIX_BITS;
   localparam int SIZE_BITS  = 13;
   localparam int COL_BITS   = 12;
   localparam int IN_ROW_BITS = 13;
   localparam int OUT_ROW_BITS = 12;
   localparam int COEF_BITS  = 16;
   localparam int WIN        = 5;
   localparam int LINES      = WIN - 1;
   localparam int NUM_CLASS  = 6;
   localparam int SUM_BITS   = 11;
   localparam int PROD_BITS  = SUM_BITS + COEF_BITS;
   localparam int ACC_BITS   = PROD_BITS + 3;
   localparam int FRAC_BITS  = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // register map, byte address is four times the index
   typedef enum logic [2:0] {
      REG_FRAME_WIDTH    = 3'd0,
      REG_FRAME_HEIGHT   = 3'd1,
      REG_COEF_CORNER    = 3'd2,
      REG_COEF_FAR_SIDE  = 3'd3,
      REG_COEF_FAR_AXIS  = 3'd4,
      REG_COEF_DIAGONAL  = 3'd5,
      REG_COEF_NEAR_AXIS = 3'd6,
      REG_COEF_CENTER    = 3'd7
   } csr_index_type;

   // kernel weight classes, same order as the coefficient registers
   typedef enum logic [2:0] {
      CLS_CORNER    = 3'd0,
      CLS_FAR_SIDE  = 3'd1,
      CLS_FAR_AXIS  = 3'd2,
      CLS_DIAGONAL  = 3'd3,
      CLS_NEAR_AXIS = 3'd4,
      CLS_CENTER    = 3'd5
   } coef_class_type;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(4096);
   localparam logic [COEF_BITS-1:0] COEF_RESET [NUM_CLASS] = '{
      16'd945, 16'd1841, 16'd2299, 16'd3585, 16'd4477, 16'd5591
   };

   typedef logic [RGB_BITS-1:0] rgb_type;

   // weight class of window place (dy, dx), both 0..4 with center at 2
   function automatic coef_class_type class_of(input int dy, input int dx);
      int ay;
      int ax;
      int lo;
      int hi;
      ay = (dy < 2) ? 2 - dy : dy - 2;
      ax = (dx < 2) ? 2 - dx : dx - 2;
      lo = (ay < ax) ? ay : ax;
      hi = (ay < ax) ? ax : ay;
      if (hi == 0) return CLS_CENTER;
      if (hi == 1) return (lo == 0) ? CLS_NEAR_AXIS : CLS_DIAGONAL;
      if (lo == 0) return CLS_FAR_AXIS;
      if (lo == 1) return CLS_FAR_SIDE;
      return CLS_CORNER;
   endfunction

endpackage
`default_nettype wire

@@ rtl/gblur_req_if.sv @@
`default_nettype none
interface gblur_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;

   modport source (output valid, action, pixel_red, pixel_green, pixel_blue, input ready);
   modport sink (input valid, action, pixel_red, pixel_green, pixel_blue, output ready);
endinterface
`default_nettype wire

@@ rtl/gblur_rsp_if.sv @@
`default_nettype none
interface gblur_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       out_last;

   modport source (output valid, out_red, out_green, out_blue, out_last, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_last, output ready);
endinterface
`default_nettype wire

@@ rtl/gblur_ram.sv @@
`default_nettype none
module gblur_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ rtl/gaussian_blur_5x5_rgb.sv @@
`default_nettype none
// streaming 5x5 gaussian blur of an rgb pixel stream in raster order
// - req_if: one request per pixel; action 0 is a frame pixel, action 1 a flush
//   tick that stands for padding after the frame (a flush at frame start is dropped)
// - rsp_if: one blurred pixel per result, out_last marks the final pixel of a frame
// - csr: apb-style write/read port for frame size and the six q0.16 weights
// - output pixel q of a frame leaves on the request at stream position q+2*w+2,
//   so 2*w+2 flush ticks after the frame drain the last two rows
// - a request is taken every cycle while the result side keeps up; the ram is read
//   at the accepting edge, then come the registered window and class sums, weight
//   multiply, add and saturate and the output register, one pixel per clock sustained
// - line history sits in one 4096 x 96 bit ram (four rows of rgb), read and
//   written once per request; no clearing pass, never-written entries land only
//   in window places that fall outside the frame
// - reset (synchronous) restores the register defaults, empties the pipeline and
//   zeroes the counters and window
// - when the receiver stalls the whole pipeline holds and req_if.ready drops
module gaussian_blur_5x5_rgb (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   gblur_req_if.sink                                   req_if,
   gblur_rsp_if.source                                 rsp_if,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [gblur_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [gblur_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic      [gblur_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                        csr_pready
);
   import gblur_pkg::*;

   // configuration registers
   logic [SIZE_BITS-1:0] frame_width_ff;
   logic [SIZE_BITS-1:0] frame_height_ff;
   logic [COEF_BITS-1:0] coef_ff [NUM_CLASS];
   csr_index_type        csr_index;
   logic                 csr_write;

   // stream counters
   logic [COL_BITS-1:0]     in_column_ff, in_column_in;
   logic [IN_ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [COL_BITS-1:0]     out_column_ff, out_column_in;
   logic [OUT_ROW_BITS-1:0] out_row_ff, out_row_in;

   // accept stage control
   logic                  adv;
   logic                  accept;
   logic                  ignore;
   logic                  emit;
   logic                  last;
   logic                  col_wrap;
   logic [SIZE_BITS-1:0]  w_eff;
   logic [SIZE_BITS-1:0]  h_eff;
   logic [26:0]           pos;
   logic [14:0]           pos_threshold;
   logic [WIN-1:0]        rmask;
   logic [WIN-1:0]        cmask;
   rgb_type               in_pix;

   // stage 1: ram data lines up with the request
   logic                  s1_valid_ff;
   logic                  s1_emit_ff;
   logic                  s1_last_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   rgb_type               s1_pix_ff;
   logic [WIN-1:0]        s1_rmask_ff;
   logic [WIN-1:0]        s1_cmask_ff;
   logic                  byp_ff;
   logic [LINES*RGB_BITS-1:0] byp_data_ff;
   logic [LINES*RGB_BITS-1:0] ram_rd_data;
   logic [LINES*RGB_BITS-1:0] lines;
   logic [LINES*RGB_BITS-1:0] ram_wr_data;
   rgb_type               window_ff [WIN][WIN];
   rgb_type               window_in [WIN][WIN];
   logic [SUM_BITS-1:0]   sum_in [3][NUM_CLASS];

   // stage 2: class sums
   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic [SUM_BITS-1:0]   s2_sum_ff [3][NUM_CLASS];

   // stage 3: weighted class sums
   logic                  s3_valid_ff;
   logic                  s3_last_ff;
   logic [PROD_BITS-1:0]  s3_prod_ff [3][NUM_CLASS];
   logic [PIX_BITS-1:0]   res_in [3];

   // output register
   logic                  rsp_valid_ff;
   logic [PIX_BITS-1:0]   rsp_red_ff;
   logic [PIX_BITS-1:0]   rsp_green_ff;
   logic [PIX_BITS-1:0]   rsp_blue_ff;
   logic                  rsp_last_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SIZE_RESET;
         frame_height_ff <= SIZE_RESET;
         for (int i = 0; i < NUM_CLASS; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:    frame_width_ff  <= csr_pwdata[SIZE_BITS-1:0];
            REG_FRAME_HEIGHT:   frame_height_ff <= csr_pwdata[SIZE_BITS-1:0];
            REG_COEF_CORNER:    coef_ff[CLS_CORNER]    <= csr_pwdata[COEF_BITS-1:0];
            REG_COEF_FAR_SIDE:  coef_ff[CLS_FAR_SIDE]  <= csr_pwdata[COEF_BITS-1:0];
            REG_COEF_FAR_AXIS:  coef_ff[CLS_FAR_AXIS]  <= csr_pwdata[COEF_BITS-1:0];
            REG_COEF_DIAGONAL:  coef_ff[CLS_DIAGONAL]  <= csr_pwdata[COEF_BITS-1:0];
            REG_COEF_NEAR_AXIS: coef_ff[CLS_NEAR_AXIS] <= csr_pwdata[COEF_BITS-1:0];
            REG_COEF_CENTER:    coef_ff[CLS_CENTER]    <= csr_pwdata[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:    csr_prdata = CSR_DATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT:   csr_prdata = CSR_DATA_BITS'(frame_height_ff);
         REG_COEF_CORNER:    csr_prdata = CSR_DATA_BITS'(coef_ff[CLS_CORNER]);
         REG_COEF_FAR_SIDE:  csr_prdata = CSR_DATA_BITS'(coef_ff[CLS_FAR_SIDE]);
         REG_COEF_FAR_AXIS:  csr_prdata = CSR_DATA_BITS'(coef_ff[CLS_FAR_AXIS]);
         REG_COEF_DIAGONAL:  csr_prdata = CSR_DATA_BITS'(coef_ff[CLS_DIAGONAL]);
         REG_COEF_NEAR_AXIS: csr_prdata = CSR_DATA_BITS'(coef_ff[CLS_NEAR_AXIS]);
         REG_COEF_CENTER:    csr_prdata = CSR_DATA_BITS'(coef_ff[CLS_CENTER]);
         default:            csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------- accept stage
   // the whole pipeline moves together; it holds only while a result waits
   assign adv          = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;
   assign accept       = req_if.valid && adv;

   // frame size in use, clamped to 1..max
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = SIZE_BITS'(1);
      end else if (frame_width_ff > SIZE_BITS'(MAX_WIDTH)) begin
         w_eff = SIZE_BITS'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = SIZE_BITS'(1);
      end else if (frame_height_ff > SIZE_BITS'(MAX_HEIGHT)) begin
         h_eff = SIZE_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // flush at the very start of a frame changes nothing
   assign ignore = req_if.action && (in_column_ff == '0) && (in_row_ff == '0);
   assign in_pix = req_if.action ? '0
                 : {req_if.pixel_blue, req_if.pixel_green, req_if.pixel_red};

   // stream position decides whether this request completes an output pixel
   assign pos           = 27'(in_row_ff * w_eff) + 27'(in_column_ff);
   assign pos_threshold = {1'b0, w_eff, 1'b0} + 15'd2;
   assign emit          = pos >= 27'(pos_threshold);
   assign last          = emit && ((14'(out_row_ff) + 14'd1) >= 14'(h_eff))
                               && ((14'(out_column_ff) + 14'd1) >= 14'(w_eff));
   assign col_wrap      = (14'(in_column_ff) + 14'd1) >= 14'(w_eff);

   // which window rows and columns fall inside the frame
   always_comb begin
      for (int d = 0; d < WIN; d++) begin
         rmask[d] = ((14'(out_row_ff) + 14'(d)) >= 14'd2)
                 && ((14'(out_row_ff) + 14'(d)) < (14'(h_eff) + 14'd2));
         cmask[d] = ((14'(out_column_ff) + 14'(d)) >= 14'd2)
                 && ((14'(out_column_ff) + 14'(d)) < (14'(w_eff) + 14'd2));
      end
   end

   always_comb begin
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (accept && !ignore) begin
         if (col_wrap) begin
            in_column_in = '0;
            if (in_row_ff != '1) begin
               in_row_in = in_row_ff + 1'b1;
            end
         end else begin
            in_column_in = in_column_ff + 1'b1;
         end
         if (last) begin
            // frame done, everything starts over
            in_column_in  = '0;
            in_row_in     = '0;
            out_column_in = '0;
            out_row_in    = '0;
         end else if (emit) begin
            if ((14'(out_column_ff) + 14'd1) >= 14'(w_eff)) begin
               out_column_in = '0;
               out_row_in    = out_row_ff + 1'b1;
            end else begin
               out_column_in = out_column_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
      end
   end

   // ------------------------------------------------------- line store
   // read at acceptance, written back from stage 1
   gblur_ram #(
      .WIDTH (LINES * RGB_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (adv && s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (adv),
      .rd_addr (in_column_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------ stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept && !ignore;
         // one-pixel rows read the entry that is being written this same edge
         byp_ff      <= s1_valid_ff && (s1_col_ff == in_column_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
         s1_col_ff   <= in_column_ff;
         s1_pix_ff   <= in_pix;
         s1_rmask_ff <= rmask;
         s1_cmask_ff <= cmask;
         byp_data_ff <= ram_wr_data;
      end
   end

   assign lines = byp_ff ? byp_data_ff : ram_rd_data;

   // shift the window left, load the new column, push rows up the line store
   always_comb begin
      for (int dy = 0; dy < WIN; dy++) begin
         for (int dx = 0; dx < WIN - 1; dx++) begin
            window_in[dy][dx] = window_ff[dy][dx+1];
         end
      end
      for (int k = 0; k < LINES; k++) begin
         window_in[k][WIN-1] = lines[k*RGB_BITS +: RGB_BITS];
      end
      window_in[WIN-1][WIN-1] = s1_pix_ff;
      for (int k = 0; k < LINES; k++) begin
         ram_wr_data[k*RGB_BITS +: RGB_BITS] = window_in[k+1][WIN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int dy = 0; dy < WIN; dy++) begin
            for (int dx = 0; dx < WIN; dx++) begin
               window_ff[dy][dx] <= '0;
            end
         end
      end else if (adv && s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   // samples that share a weight are added before the multiply
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int c = 0; c < NUM_CLASS; c++) begin
            sum_in[ch][c] = '0;
         end
         for (int dy = 0; dy < WIN; dy++) begin
            for (int dx = 0; dx < WIN; dx++) begin
               if (s1_rmask_ff[dy] && s1_cmask_ff[dx]) begin
                  sum_in[ch][int'(class_of(dy, dx))] = sum_in[ch][int'(class_of(dy, dx))]
                     + SUM_BITS'(window_in[dy][dx][ch*PIX_BITS +: PIX_BITS]);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------ stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_last_ff <= s1_last_ff;
         s2_sum_ff  <= sum_in;
      end
   end

   // ------------------------------------------------------------ stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_last_ff <= s2_last_ff;
         for (int ch = 0; ch < 3; ch++) begin
            for (int c = 0; c < NUM_CLASS; c++) begin
               s3_prod_ff[ch][c] <= PROD_BITS'(s2_sum_ff[ch][c] * coef_ff[c]);
            end
         end
      end
   end

   // add, truncate the fraction, saturate
   always_comb begin
      logic [ACC_BITS-1:0] acc;
      for (int ch = 0; ch < 3; ch++) begin
         acc = '0;
         for (int c = 0; c < NUM_CLASS; c++) begin
            acc = acc + ACC_BITS'(s3_prod_ff[ch][c]);
         end
         if (acc[ACC_BITS-1:FRAC_BITS] > (ACC_BITS - FRAC_BITS)'(255)) begin
            res_in[ch] = '1;
         end else begin
            res_in[ch] = acc[FRAC_BITS +: PIX_BITS];
         end
      end
   end

   // ---------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_ff   <= res_in[0];
         rsp_green_ff <= res_in[1];
         rsp_blue_ff  <= res_in[2];
         rsp_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_red   = rsp_red_ff;
   assign rsp_if.out_green = rsp_green_ff;
   assign rsp_if.out_blue  = rsp_blue_ff;
   assign rsp_if.out_last  = rsp_last_ff;

`ifndef ASSERT_OFF
   // a waiting result blocks new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !req_if.ready)
      else $error("request taken while result stalled");

   // the final pixel of a frame returns all counters to zero
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && !ignore && last) |=>
         (in_column_ff == '0 && in_row_ff == '0 && out_column_ff == '0
          && out_row_ff == '0))
      else $error("counters not cleared at frame end");

   // a result only appears when stage 3 held one
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff))
      else $error("result without pipeline item");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top;
   import gblur_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } blur_pix_type;

   typedef struct {
      bit         flush;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         typed;
      blur_pix_type want;
   } demo_row_type;

   logic clock;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   gblur_req_if req_if ();
   gblur_rsp_if rsp_if ();

   gaussian_blur_5x5_rgb DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow copy of the block: registers, line history, window, counters
   logic [12:0] shadow_width;
   logic [12:0] shadow_height;
   logic [15:0] shadow_coef [NUM_CLASS];
   rgb_type     shadow_lines [LINES][MAX_WIDTH];
   rgb_type     shadow_win [WIN][WIN];
   int unsigned in_col_cnt;
   int unsigned in_row_cnt;
   int unsigned out_col_cnt;
   int unsigned out_row_cnt;

   blur_pix_type blurred_fifo [$];
   int           err_count;
   int           result_count;
   int           random_items;
   bit           burst_mode;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit, well above the slowest legal run
   initial begin
      #(4 * 4_000_000);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      err_count++;
   endtask

   function automatic int unsigned clamp_dim(input logic [12:0] v);
      if (v == 0) return 1;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return v;
   endfunction

   // weight for absolute offsets, symmetric in the two axes
   function automatic logic [15:0] kernel_weight(input int ay, input int ax);
      int lo;
      int hi;
      lo = (ay < ax) ? ay : ax;
      hi = (ay < ax) ? ax : ay;
      if (hi == 0) return shadow_coef[CLS_CENTER];
      if (hi == 1) return (lo == 0) ? shadow_coef[CLS_NEAR_AXIS] : shadow_coef[CLS_DIAGONAL];
      if (lo == 0) return shadow_coef[CLS_FAR_AXIS];
      if (lo == 1) return shadow_coef[CLS_FAR_SIDE];
      return shadow_coef[CLS_CORNER];
   endfunction

   function automatic void shadow_reset();
      shadow_width  = 13'd4096;
      shadow_height = 13'd4096;
      shadow_coef[CLS_CORNER]    = 16'd945;
      shadow_coef[CLS_FAR_SIDE]  = 16'd1841;
      shadow_coef[CLS_FAR_AXIS]  = 16'd2299;
      shadow_coef[CLS_DIAGONAL]  = 16'd3585;
      shadow_coef[CLS_NEAR_AXIS] = 16'd4477;
      shadow_coef[CLS_CENTER]    = 16'd5591;
      for (int k = 0; k < LINES; k++)
         for (int c = 0; c < MAX_WIDTH; c++) shadow_lines[k][c] = '0;
      for (int y = 0; y < WIN; y++)
         for (int x = 0; x < WIN; x++) shadow_win[y][x] = '0;
      in_col_cnt  = 0;
      in_row_cnt  = 0;
      out_col_cnt = 0;
      out_row_cnt = 0;
   endfunction

   // advance the shadow by one request, returns 1 when a blurred pixel is due
   function automatic bit blur_predict(input bit flush, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b,
                                       output blur_pix_type res);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned pos;
      rgb_type     pix;
      longint      acc;
      longint      q;
      int          ry;
      int          cx;
      logic [7:0]  chan [3];
      w = clamp_dim(shadow_width);
      h = clamp_dim(shadow_height);
      res = '0;
      // flush with nothing in flight is dropped
      if (flush && in_col_cnt == 0 && in_row_cnt == 0) return 1'b0;
      pix = flush ? '0 : {b, g, r};
      col = in_col_cnt % MAX_WIDTH;
      pos = in_row_cnt * w + in_col_cnt;
      for (int y = 0; y < WIN; y++)
         for (int x = 0; x < WIN - 1; x++) shadow_win[y][x] = shadow_win[y][x+1];
      for (int k = 0; k < LINES; k++) shadow_win[k][WIN-1] = shadow_lines[k][col];
      shadow_win[WIN-1][WIN-1] = pix;
      for (int k = 0; k < LINES; k++) shadow_lines[k][col] = shadow_win[k+1][WIN-1];
      if (in_col_cnt + 1 >= w) begin
         in_col_cnt = 0;
         if (in_row_cnt < 8191) in_row_cnt++;
      end else begin
         in_col_cnt++;
      end
      if (pos < 2 * w + 2) return 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
         acc = 0;
         for (int dy = -2; dy <= 2; dy++) begin
            ry = int'(out_row_cnt) + dy;
            if (ry < 0 || ry >= int'(h)) continue;
            for (int dx = -2; dx <= 2; dx++) begin
               cx = int'(out_col_cnt) + dx;
               if (cx < 0 || cx >= int'(w)) continue;
               acc += longint'(shadow_win[dy+2][dx+2][8*ch +: 8]) *
                      longint'(kernel_weight(dy < 0 ? -dy : dy, dx < 0 ? -dx : dx));
            end
         end
         q = acc >> 16;
         chan[ch] = (q > 255) ? 8'd255 : q[7:0];
      end
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      if (out_row_cnt + 1 >= h && out_col_cnt + 1 >= w) begin
         res.last    = 1'b1;
         in_col_cnt  = 0;
         in_row_cnt  = 0;
         out_col_cnt = 0;
         out_row_cnt = 0;
      end else if (out_col_cnt + 1 >= w) begin
         out_col_cnt = 0;
         out_row_cnt++;
      end else begin
         out_col_cnt++;
      end
      return 1'b1;
   endfunction

   // apb write: setup then access, written at the access edge
   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:    shadow_width  = val[12:0];
         REG_FRAME_HEIGHT:   shadow_height = val[12:0];
         default:            shadow_coef[int'(idx) - 2] = val[15:0];
      endcase
   endtask

   task automatic csr_check(input csr_index_type idx, input logic [31:0] want);
      logic [31:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_BITS'(idx) << 2;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got != want)
         report_mismatch($sformatf("register %s reads %0d, want %0d", idx.name(), got, want));
   endtask

   task automatic check_all_regs();
      csr_check(REG_FRAME_WIDTH, 32'(shadow_width));
      csr_check(REG_FRAME_HEIGHT, 32'(shadow_height));
      for (int c = 0; c < NUM_CLASS; c++)
         csr_check(csr_index_type'(c + 2), 32'(shadow_coef[c]));
   endtask

   // wait until all blurred pixels are out, then let the pipeline go quiet
   task automatic wait_drained();
      while (blurred_fifo.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // offer one request after a random gap (none in burst mode), predict on acceptance
   task automatic send_pixel(input bit flush, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input bit typed, input blur_pix_type want);
      int           gap;
      bit           due;
      blur_pix_type res;
      gap = burst_mode ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= flush;
      req_if.pixel_red   <= r;
      req_if.pixel_green <= g;
      req_if.pixel_blue  <= b;
      do @(posedge clock); while (!req_if.ready);
      due = blur_predict(flush, r, g, b, res);
      if (due) blurred_fifo.push_back(typed ? want : res);
   endtask

   function automatic logic [7:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] rand_coef(input int c);
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(0, 6000));
         default: return (c == CLS_CENTER) ? 16'd5591 : 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // receiver: random stall per result outside burst mode, one long hold-off to back up the pipe
   initial begin
      int  hold;
      bit  long_done;
      long_done = 1'b0;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!long_done && result_count >= 400) begin
            hold = 300;
            long_done = 1'b1;
         end else begin
            hold = burst_mode ? 0 : $urandom_range(0, 12);
         end
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // compare every accepted blurred pixel with the oldest prediction
   always @(posedge clock) begin
      blur_pix_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         result_count++;
         if (blurred_fifo.size() == 0) begin
            report_mismatch("blurred pixel with nothing predicted");
         end else begin
            want = blurred_fifo.pop_front();
            if (rsp_if.out_red !== want.red)
               report_mismatch($sformatf("red %0d want %0d", rsp_if.out_red, want.red));
            if (rsp_if.out_green !== want.green)
               report_mismatch($sformatf("green %0d want %0d", rsp_if.out_green, want.green));
            if (rsp_if.out_blue !== want.blue)
               report_mismatch($sformatf("blue %0d want %0d", rsp_if.out_blue, want.blue));
            if (rsp_if.out_last !== want.last)
               report_mismatch($sformatf("last %0b want %0b", rsp_if.out_last, want.last));
         end
      end
   end

   // directed frames at 1x1 with a pure center weight of 65535
   // flush at frame start, drain-phase pixel, extremes of every channel
   demo_row_type demo_rows [16] = '{
      '{1'b1, 8'd9,   8'd9,   8'd9,   1'b0, '0},
      '{1'b0, 8'd255, 8'd0,   8'd128, 1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{1'b0, 8'd1,   8'd2,   8'd3,   1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd254, 8'd0, 8'd127, 1'b1}},
      '{1'b0, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
      '{1'b0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{1'b0, 8'd170, 8'd85,  8'd170, 1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd254, 8'd254, 8'd254, 1'b1}}
   };

   initial begin
      int          fw;
      int          fh;
      int          n_items;
      int          n_frame;
      int          phase;
      bit          flush;
      logic [12:0] wr_w;
      logic [12:0] wr_h;
      err_count    = 0;
      result_count = 0;
      random_items = 0;
      burst_mode   = 1'b0;
      reset        = 1'b1;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      req_if.valid       = 1'b0;
      req_if.action      = 1'b0;
      req_if.pixel_red   = '0;
      req_if.pixel_green = '0;
      req_if.pixel_blue  = '0;
      shadow_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults after reset
      check_all_regs();

      // directed part
      csr_write(REG_FRAME_WIDTH, 32'd1);
      csr_write(REG_FRAME_HEIGHT, 32'd1);
      for (int c = 0; c < NUM_CLASS; c++)
         csr_write(csr_index_type'(c + 2), (c == CLS_CENTER) ? 32'hFFFF : 32'd0);
      foreach (demo_rows[i])
         send_pixel(demo_rows[i].flush, demo_rows[i].red, demo_rows[i].green,
                    demo_rows[i].blue, demo_rows[i].typed, demo_rows[i].want);
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait_drained();

      // random frames, two of them at the size extremes and one written as zero by zero
      phase = 0;
      while (random_items < 1200 || phase < 10) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         case (phase)
            3: begin wr_w = 13'd8191; wr_h = 13'd1;    end
            6: begin wr_w = 13'd1;    wr_h = 13'd4096; end
            8: begin wr_w = 13'd0;    wr_h = 13'd0;    end
            default: begin
               wr_w = 13'($urandom_range(1, 10));
               wr_h = 13'($urandom_range(1, 6));
            end
         endcase
         csr_write(REG_FRAME_WIDTH, 32'(wr_w));
         csr_write(REG_FRAME_HEIGHT, 32'(wr_h));
         for (int c = 0; c < NUM_CLASS; c++)
            csr_write(csr_index_type'(c + 2), 32'(rand_coef(c)));
         check_all_regs();
         fw = clamp_dim(wr_w);
         fh = clamp_dim(wr_h);
         n_frame = fw * fh;
         n_items = n_frame + 2 * fw + 2;
         // size extremes get only the start of a frame; from then on a frame is
         // now and then cut short so the next size change lands mid-frame
         if (phase == 3 || phase == 6) begin
            n_items = 40;
         end else if (phase > 3 && $urandom_range(0, 7) == 0) begin
            n_items = $urandom_range(1, n_items);
         end
         for (int i = 0; i < n_items; i++) begin
            flush = (i >= n_frame);
            // the first request of a frame keeps its planned kind
            if (i > 0 && $urandom_range(0, 15) == 0) flush = ~flush;
            send_pixel(flush, rand_sample(), rand_sample(), rand_sample(), 1'b0, '0);
            random_items++;
         end
         @(negedge clock);
         req_if.valid <= 1'b0;
         wait_drained();
         phase++;
      end

      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
rtl/gblur_pkg.sv
rtl/gblur_req_if.sv
rtl/gblur_rsp_if.sv
rtl/gblur_ram.sv
rtl/gaussian_blur_5x5_rgb.sv
sim/tb_top.sv
